// ===== hdl/fa_pkg.sv =====
// shared types and constants for the fraction accumulator
`default_nettype none
package fa_pkg;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned ReqWidth  = 2;

    localparam logic [ReqWidth-1:0] ReqLoad = 2'd0;
    localparam logic [ReqWidth-1:0] ReqAdd  = 2'd1;
    localparam logic [ReqWidth-1:0] ReqMul  = 2'd2;

    // datapath operations issued by the controller
    localparam logic [2:0] OpNone    = 3'd0;
    localparam logic [2:0] OpLoad    = 3'd1;
    localparam logic [2:0] OpMulA    = 3'd2;
    localparam logic [2:0] OpMulB    = 3'd3;
    localparam logic [2:0] OpSum     = 3'd4;
    localparam logic [2:0] OpGcdInit = 3'd5;
    localparam logic [2:0] OpDivInit = 3'd6;

    typedef struct packed {
        logic [2:0]          op;
        logic [ReqWidth-1:0] req;
        logic                gcd_start;
        logic                div_start;
        logic                div_commit;
        logic                commit;
    } t_cmd;

    typedef struct packed {
        logic reducible;
        logic gcd_busy;
        logic div_busy;
        logic gcd_big;
    } t_status;
endpackage
`default_nettype wire

// ===== hdl/fa_if.sv =====
// valid/ready channel interfaces for request and result transactions
`default_nettype none
interface fa_req_if;
    logic                           valid;
    logic                           ready;
    logic [fa_pkg::ReqWidth-1:0]    req_type;
    logic signed [fa_pkg::DataWidth-1:0] num_in;
    logic signed [fa_pkg::DataWidth-1:0] den_in;
    modport source (output valid, req_type, num_in, den_in, input ready);
    modport sink   (input valid, req_type, num_in, den_in, output ready);
endinterface

interface fa_res_if;
    logic                           valid;
    logic                           ready;
    logic signed [fa_pkg::DataWidth-1:0] num_out;
    logic signed [fa_pkg::DataWidth-1:0] den_out;
    modport source (output valid, num_out, den_out, input ready);
    modport sink   (input valid, num_out, den_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/fa_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module fa_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [fa_pkg::DataWidth-1:0]  i_dividend,
    input  wire logic [fa_pkg::DataWidth-1:0]  i_divisor,
    output logic                               o_busy,
    output logic [fa_pkg::DataWidth-1:0]       o_quot,
    output logic [fa_pkg::DataWidth-1:0]       o_rem
);
    localparam int unsigned W = fa_pkg::DataWidth;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quot, r_rem, r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    // shift in next dividend bit and try to subtract
    assign w_trial = {r_rem, r_quot[W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                r_rem  <= w_diff[W-1:0];
                r_quot <= {r_quot[W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial[W-1:0];
                r_quot <= {r_quot[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ===== hdl/fa_datapath.sv =====
// fraction registers, shared multiplier, gcd loop and divider
`default_nettype none
module fa_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fa_pkg::t_cmd                  i_cmd,
    input  wire logic [fa_pkg::DataWidth-1:0]  i_num,
    input  wire logic [fa_pkg::DataWidth-1:0]  i_den,
    output fa_pkg::t_status                    o_status,
    output logic [fa_pkg::DataWidth-1:0]       o_num,
    output logic [fa_pkg::DataWidth-1:0]       o_den
);
    localparam int unsigned W = fa_pkg::DataWidth;

    logic [W-1:0] r_hn, r_hd;       // held fraction
    logic [W-1:0] r_on, r_od;       // operand
    logic [W-1:0] r_tn, r_td;       // candidate fraction
    logic [W-1:0] r_p0, r_p1;       // products
    logic [W-1:0] r_ga, r_gb;       // euclid pair
    logic         r_div_den;        // divider phase: 0 numerator, 1 denominator
    logic [W-1:0] w_ma, w_mb, w_prod;
    logic         w_div_busy;
    logic [W-1:0] w_quot, w_rem, w_dvd;

    // one shared 32x32 multiplier, low half kept
    always_comb begin
        case (i_cmd.op)
            fa_pkg::OpMulA: begin
                w_ma = r_hn;
                w_mb = (i_cmd.req == fa_pkg::ReqMul) ? r_on : r_od;
            end
            fa_pkg::OpMulB: begin
                w_ma = (i_cmd.req == fa_pkg::ReqMul) ? r_hd : r_on;
                w_mb = (i_cmd.req == fa_pkg::ReqMul) ? r_od : r_hd;
            end
            default: begin
                w_ma = r_hd;
                w_mb = r_od;
            end
        endcase
    end
    assign w_prod = W'(w_ma * w_mb);

    assign w_dvd = r_div_den ? r_td : r_tn;

    fa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.gcd_start | i_cmd.div_start),
        .i_dividend (i_cmd.gcd_start ? r_ga : w_dvd),
        .i_divisor  (i_cmd.gcd_start ? r_gb : r_ga),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // operand, candidate, product and euclid pair registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            fa_pkg::OpLoad: begin
                r_on <= i_num;
                r_od <= i_den;
                r_tn <= i_num;
                r_td <= i_den;
            end
            fa_pkg::OpMulA: r_p0 <= w_prod;
            fa_pkg::OpMulB: r_p1 <= w_prod;
            fa_pkg::OpSum: begin
                r_tn <= (i_cmd.req == fa_pkg::ReqMul) ? r_p0 : r_p0 + r_p1;
                r_td <= (i_cmd.req == fa_pkg::ReqMul) ? r_p1 : w_prod;
            end
            fa_pkg::OpGcdInit: begin
                r_ga <= r_tn;
                r_gb <= r_td;
            end
            fa_pkg::OpDivInit: r_div_den <= 1'b0;
            default: ;
        endcase
        // division result write-back, or one euclid step when the remainder is ready
        if (i_cmd.div_commit) begin
            if (r_div_den) begin
                r_td <= w_quot;
            end else begin
                r_tn      <= w_quot;
                r_div_den <= 1'b1;
            end
        end else if (i_cmd.gcd_start == 1'b0 && i_cmd.op == fa_pkg::OpNone
                     && !w_div_busy && o_status.gcd_busy) begin
            r_ga <= r_gb;
            r_gb <= w_rem;
        end
    end

    // held fraction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hn <= '0;
            r_hd <= W'(1);
        end else if (i_cmd.commit) begin
            r_hn <= r_tn;
            r_hd <= r_td;
        end
    end

    assign o_status.reducible = !r_tn[W-1] && (r_tn >= W'(2))
                                && !r_td[W-1] && (r_td >= W'(2));
    assign o_status.div_busy  = w_div_busy;
    assign o_status.gcd_busy  = (r_gb != '0);
    assign o_status.gcd_big   = (r_ga >= W'(2));
    assign o_num = r_hn;
    assign o_den = r_hd;
endmodule
`default_nettype wire

// ===== hdl/fa_ctrl.sv =====
// request sequencer: arithmetic, gcd loop, division and result hand-off
`default_nettype none
module fa_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    fa_req_if.sink                         s_req,
    input  wire logic                      i_res_ready,
    output logic                           o_res_valid,
    input  wire fa_pkg::t_status           i_status,
    output fa_pkg::t_cmd                   o_cmd
);
    localparam logic [3:0] StIdle   = 4'd0;
    localparam logic [3:0] StMulA   = 4'd1;
    localparam logic [3:0] StMulB   = 4'd2;
    localparam logic [3:0] StSum    = 4'd3;
    localparam logic [3:0] StCheck  = 4'd4;
    localparam logic [3:0] StGcdGo  = 4'd5;
    localparam logic [3:0] StGcdW   = 4'd6;
    localparam logic [3:0] StGcdSt  = 4'd7;
    localparam logic [3:0] StDivGo  = 4'd8;
    localparam logic [3:0] StDivW   = 4'd9;
    localparam logic [3:0] StCommit = 4'd10;
    localparam logic [3:0] StOut    = 4'd11;

    logic [3:0]                  r_state, n_state;
    logic [fa_pkg::ReqWidth-1:0] r_req;
    logic                        r_second;
    logic                        w_take;

    assign s_req.ready = (r_state == StIdle);
    assign w_take      = s_req.valid && s_req.ready;
    assign o_res_valid = (r_state == StOut);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.req = r_req;
        case (r_state)
            StIdle: if (w_take) begin
                if (s_req.req_type == fa_pkg::ReqLoad) begin
                    o_cmd.op = fa_pkg::OpLoad;
                    n_state  = StCheck;
                end else if (s_req.req_type == fa_pkg::ReqAdd
                             || s_req.req_type == fa_pkg::ReqMul) begin
                    o_cmd.op = fa_pkg::OpLoad;
                    n_state  = StMulA;
                end else begin
                    n_state = StOut;
                end
            end
            StMulA: begin o_cmd.op = fa_pkg::OpMulA; n_state = StMulB; end
            StMulB: begin o_cmd.op = fa_pkg::OpMulB; n_state = StSum;  end
            StSum:  begin o_cmd.op = fa_pkg::OpSum;  n_state = StCheck; end
            StCheck: begin
                if (i_status.reducible) begin
                    o_cmd.op = fa_pkg::OpGcdInit;
                    n_state  = StGcdSt;
                end else begin
                    n_state = StCommit;
                end
            end
            StGcdSt: begin
                if (i_status.gcd_busy) begin
                    o_cmd.gcd_start = 1'b1;
                    n_state = StGcdW;
                end else if (i_status.gcd_big) begin
                    o_cmd.op = fa_pkg::OpDivInit;
                    n_state  = StDivGo;
                end else begin
                    n_state = StCommit;
                end
            end
            StGcdW: if (!i_status.div_busy) begin
                n_state = StGcdSt;   // datapath swaps pair this cycle
            end
            StDivGo: begin o_cmd.div_start = 1'b1; n_state = StDivW; end
            StDivW: if (!i_status.div_busy) begin
                o_cmd.div_commit = 1'b1;
                n_state = r_second ? StCommit : StDivGo;
            end
            StCommit: begin o_cmd.commit = 1'b1; n_state = StOut; end
            StOut: if (i_res_ready) begin n_state = StIdle; end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_req    <= fa_pkg::ReqLoad;
            r_second <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) r_req <= s_req.req_type;
            if (o_cmd.op == fa_pkg::OpDivInit) r_second <= 1'b0;
            else if (o_cmd.div_commit) r_second <= 1'b1;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_req.ready |-> !o_res_valid) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid) else $error("result dropped");
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_res_valid) else $error("commit without result");
endmodule
`default_nettype wire

// ===== hdl/fraction_accumulator.sv =====
// top level of the fraction accumulator
// Usage: a request transaction on s_req carries req_type (0 load, 1 add,
// 2 multiply, 3 read back) and an operand fraction num_in/den_in. One
// result transaction on m_res returns the new held fraction, reduced by
// the gcd of both parts when both are at least two.
// One request is in flight at a time; s_req.ready is high only when idle,
// so the next request is taken at the earliest in the cycle after the result
// transaction.
// A read back goes straight to the result, a load passes the reduction check
// and commit, and add or multiply first take two multiply steps and a sum.
// With reduction each Euclid step runs one division on the shared
// bit-serial divider, plus two divisions when the gcd is at least two.
// The radix-2 divider, one bit per cycle, dominates the time of a reduction.
// Reset (synchronous, active low) sets the held fraction to 0/1.
// When the receiver stalls, the result stays on m_res and no new request
// is taken until it is accepted.
`default_nettype none
module fraction_accumulator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fa_req_if.sink    s_req,
    fa_res_if.source  m_res
);
    fa_pkg::t_cmd    w_cmd;
    fa_pkg::t_status w_status;
    logic [fa_pkg::DataWidth-1:0] w_num, w_den;

    fa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_req       (s_req),
        .i_res_ready (m_res.ready),
        .o_res_valid (m_res.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    fa_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_num    (s_req.num_in),
        .i_den    (s_req.den_in),
        .o_status (w_status),
        .o_num    (w_num),
        .o_den    (w_den)
    );

    assign m_res.num_out = w_num;
    assign m_res.den_out = w_den;
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for the fraction accumulator: directed and random requests, predicted results
`default_nettype none
module tb_top;
    typedef struct packed {
        logic [fa_pkg::ReqWidth-1:0]  req;
        logic [fa_pkg::DataWidth-1:0] num;
        logic [fa_pkg::DataWidth-1:0] den;
    } t_request;

    typedef struct packed {
        logic [fa_pkg::DataWidth-1:0] num;
        logic [fa_pkg::DataWidth-1:0] den;
    } t_fraction;

    localparam logic [fa_pkg::ReqWidth-1:0] ReqReadBack = 2'd3;
    localparam int unsigned CycleLimit = 20000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fa_req_if req_ch ();
    fa_res_if res_ch ();

    fraction_accumulator DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_req  (req_ch.sink),
        .m_res  (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_request  pending_reqs[$];
    t_fraction expected_fracs[$];
    logic [fa_pkg::DataWidth-1:0] held_num = '0;
    logic [fa_pkg::DataWidth-1:0] held_den = 32'd1;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit stim_done = 1'b0;
    bit drain_hold = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;

    // gap length: mostly short, sometimes long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // euclid on unsigned 32-bit values
    function automatic logic [fa_pkg::DataWidth-1:0] gcd32(
            logic [fa_pkg::DataWidth-1:0] a,
            logic [fa_pkg::DataWidth-1:0] b);
        logic [fa_pkg::DataWidth-1:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // advance the held fraction by one request
    function automatic t_fraction next_fraction(t_request rq);
        logic [fa_pkg::DataWidth-1:0] g;
        case (rq.req)
            fa_pkg::ReqLoad: begin
                held_num = rq.num;
                held_den = rq.den;
            end
            fa_pkg::ReqAdd: begin
                held_num = held_num * rq.den + rq.num * held_den;
                held_den = held_den * rq.den;
            end
            fa_pkg::ReqMul: begin
                held_num = held_num * rq.num;
                held_den = held_den * rq.den;
            end
            default: ;
        endcase
        if (rq.req != ReqReadBack
                && !held_num[fa_pkg::DataWidth-1] && held_num >= 2
                && !held_den[fa_pkg::DataWidth-1] && held_den >= 2) begin
            g = gcd32(held_num, held_den);
            if (g >= 2) begin
                held_num = held_num / g;
                held_den = held_den / g;
            end
        end
        return '{num: held_num, den: held_den};
    endfunction

    // operand value: mostly small so gcd searches stay short
    function automatic logic [fa_pkg::DataWidth-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 200);
        if (r < 75) return -$urandom_range(0, 200);
        if (r < 85) return $urandom_range(0, 100000);
        return $urandom;
    endfunction

    function automatic t_request make_request(logic [fa_pkg::ReqWidth-1:0] rq,
                                              logic [fa_pkg::DataWidth-1:0] n,
                                              logic [fa_pkg::DataWidth-1:0] d);
        return '{req: rq, num: n, den: d};
    endfunction

    // append a request to the pending queue
    function automatic void queue_req(t_request rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endfunction

    // stimulus and end of run
    initial begin
        t_request rq;
        int unsigned r;
        // directed: extremes, every request, unreducible parts, read back
        queue_req(make_request(ReqReadBack, 32'd0, 32'd0));
        queue_req(make_request(fa_pkg::ReqLoad, 32'd12, 32'd18));
        queue_req(make_request(fa_pkg::ReqAdd, 32'd1, 32'd6));
        queue_req(make_request(fa_pkg::ReqMul, 32'd3, 32'd4));
        queue_req(make_request(ReqReadBack, 32'hFFFFFFFF, 32'hFFFFFFFF));
        queue_req(make_request(fa_pkg::ReqLoad, 32'h7FFFFFFF, 32'h7FFFFFFF));
        queue_req(make_request(fa_pkg::ReqLoad, 32'h80000000, 32'h80000000));
        queue_req(make_request(fa_pkg::ReqMul, 32'hFFFFFFFF, 32'hFFFFFFFF));
        queue_req(make_request(fa_pkg::ReqLoad, 32'd0, 32'd0));
        queue_req(make_request(fa_pkg::ReqAdd, 32'd5, 32'd0));
        queue_req(make_request(fa_pkg::ReqLoad, 32'd1, 32'd8));
        queue_req(make_request(fa_pkg::ReqLoad, 32'hFFFFFFFA, 32'd4));
        queue_req(make_request(fa_pkg::ReqLoad, 32'd6, 32'hFFFFFFFC));
        queue_req(make_request(fa_pkg::ReqLoad, 32'h40000000, 32'h20000000));
        queue_req(make_request(fa_pkg::ReqMul, 32'h00010000, 32'h00010000));
        queue_req(make_request(fa_pkg::ReqLoad, 32'h7FFFFFFE, 32'h00000002));
        queue_req(make_request(fa_pkg::ReqAdd, 32'h7FFFFFFF, 32'h80000000));
        queue_req(make_request(fa_pkg::ReqLoad, 32'd2, 32'd2));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // random sequences of requests
        for (int i = 0; i < 1800; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) rq.req = fa_pkg::ReqLoad;
            else if (r < 60) rq.req = fa_pkg::ReqAdd;
            else if (r < 95) rq.req = fa_pkg::ReqMul;
            else rq.req = ReqReadBack;
            rq.num = pick_value();
            rq.den = pick_value();
            queue_req(rq);
            if (i == 900) begin
                wait (pending_reqs.size() == 0 && !req_ch.valid);
                drain_hold = 1'b1;
                wait (expected_fracs.size() == 0);
                drain_hold = 1'b0;
            end
        end
        wait (pending_reqs.size() == 0 && !req_ch.valid);
        wait (expected_fracs.size() == 0);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    logic req_taken;
    always @(posedge i_clk) begin
        req_taken <= req_ch.valid && req_ch.ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
        // predict on acceptance
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            expected_fracs.insert(expected_fracs.size(), next_fraction(
                make_request(req_ch.req_type, req_ch.num_in, req_ch.den_in)));
        end
        // result monitor
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_fracs.size() == 0) begin
                $display("%0t: unexpected result %h/%h", $time,
                         res_ch.num_out, res_ch.den_out);
                error_count++;
            end else begin
                t_fraction exp_frac;
                exp_frac = expected_fracs.pop_front();
                if (res_ch.num_out !== exp_frac.num) begin
                    $display("%0t: num_out expected %h actual %h", $time,
                             exp_frac.num, res_ch.num_out);
                    error_count++;
                end
                if (res_ch.den_out !== exp_frac.den) begin
                    $display("%0t: den_out expected %h actual %h", $time,
                             exp_frac.den, res_ch.den_out);
                    error_count++;
                end
            end
        end
    end

    // drive requests and result ready at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= '0;
            req_ch.num_in   <= '0;
            req_ch.den_in   <= '0;
            res_ch.ready    <= 1'b0;
        end else begin
            if (req_ch.valid && !req_taken) begin
                // hold the transaction until accepted
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !drain_hold) begin
                t_request nxt;
                nxt = pending_reqs.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= nxt.req;
                req_ch.num_in   <= nxt.num;
                req_ch.den_in   <= nxt.den;
                send_gap        <= pick_gap();
            end else begin
                req_ch.valid <= 1'b0;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (res_ch.valid && res_ch.ready) recv_gap <= pick_gap();
            end
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.num_in = '0;
        req_ch.den_in = '0;
        res_ch.ready = 1'b0;
        req_taken = 1'b0;
    end
endmodule
`default_nettype wire

// ===== fraction_accumulator.f =====
hdl/fa_pkg.sv
hdl/fa_if.sv
hdl/fa_divider.sv
hdl/fa_datapath.sv
hdl/fa_ctrl.sv
hdl/fraction_accumulator.sv
sim/tb_top.sv
